// File: hw/rtl/pqts_pkg.sv
// Shared types and constants of the priority quantum task scheduler.
// Used by pqts_ctrl, pqts_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package pqts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int OP_W    = 3;
  localparam int PRIO_W  = 8;
  localparam int QUANT_W = 8;
  localparam int TICK_W  = 8;
  localparam int LOCK_W  = 8;
  localparam int TASK_W  = 4;
  localparam int STAT_W  = 2;

  localparam int IN_DATA_W  = ((OP_W + PRIO_W + QUANT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * TASK_W + STAT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_YIELD  = 3'd2,
    OP_LOCK   = 3'd3,
    OP_UNLOCK = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_LOCKED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REFILL,
    S_HANDOFF,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic idx_clr;
    logic scan;
    logic refill;
    logic handoff;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic idx_last;
    logic pick_found;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/pqts_ctrl.sv
// Controller state machine of the task scheduler: sequences op execution,
// slot scan, refill pass and lock handoff. Depends on pqts_pkg.
`timescale 1ns / 1ps

module pqts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  pqts_pkg::dp_sts_t sts,
  output pqts_pkg::dp_cmd_t cmd
);

  import pqts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.tick_go ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (sts.idx_last) state_next = sts.pick_found ? S_HANDOFF : S_REFILL;
      end
      S_REFILL: begin
        if (sts.idx_last) state_next = S_HANDOFF;
      end
      S_HANDOFF: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = !rst;
        cmd.load_in   = s_axis_tvalid && !rst;
      end
      S_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      S_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.idx_clr = sts.idx_last && !sts.pick_found;
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
      end
      S_HANDOFF: begin
        cmd.handoff = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/pqts_datapath.sv
// Datapath of the task scheduler: slot table, running slot, scan and pick
// registers, result register. Driven by pqts_ctrl; depends on pqts_pkg.
`timescale 1ns / 1ps

module pqts_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  pqts_pkg::dp_cmd_t                   cmd,
  output pqts_pkg::dp_sts_t                   sts,
  // op [2:0], new_priority [10:3], new_quantum [18:11], zero fill above
  input  logic [pqts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // current_task [3:0], created_task [7:4], status [9:8], zero fill above
  output logic [pqts_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  import pqts_pkg::*;

  localparam logic [LOCK_W-1:0] LOCK_MAX = '1;

  logic [OP_W-1:0]    op_q;
  logic [PRIO_W-1:0]  prio_q;
  logic [QUANT_W-1:0] quant_q;

  logic [PRIO_W-1:0]  slot_prio  [MAX_TASKS];
  logic [QUANT_W-1:0] slot_quant [MAX_TASKS];
  logic [TICK_W-1:0]  slot_ticks [MAX_TASKS];
  logic [LOCK_W-1:0]  slot_lock  [MAX_TASKS];

  logic [SLOT_W-1:0]  running;
  logic [CNT_W-1:0]   used;

  logic [SLOT_W-1:0]  idx;
  logic               found;
  logic [SLOT_W-1:0]  best;
  logic [PRIO_W-1:0]  best_prio;

  logic [TASK_W-1:0]  res_created;
  status_t            res_status;
  logic [TASK_W-1:0]  out_cur;
  logic [TASK_W-1:0]  out_created;
  status_t            out_status;

  logic [SLOT_W-1:0]  rd_addr;
  logic [PRIO_W-1:0]  prio_rd;
  logic [QUANT_W-1:0] quant_rd;
  logic [TICK_W-1:0]  ticks_rd;
  logic [LOCK_W-1:0]  lock_rd;
  logic               slot_ok;
  logic               cand;
  logic               table_full;
  logic [SLOT_W-1:0]  new_slot;
  logic [QUANT_W-1:0] quant_eff;

  always_comb begin
    if (cmd.scan || cmd.refill) begin
      rd_addr = idx;
    end else if (cmd.handoff) begin
      rd_addr = best;
    end else begin
      rd_addr = running;
    end
  end

  assign prio_rd    = slot_prio[rd_addr];
  assign quant_rd   = slot_quant[rd_addr];
  assign ticks_rd   = slot_ticks[rd_addr];
  assign lock_rd    = slot_lock[rd_addr];
  assign slot_ok    = CNT_W'(idx) < used;
  assign cand       = slot_ok && (cmd.refill || ticks_rd != '0)
                      && (!found || prio_rd > best_prio);
  assign table_full = used >= CNT_W'(MAX_TASKS);
  assign new_slot   = used[SLOT_W-1:0];
  assign quant_eff  = (quant_q == '0) ? QUANT_W'(1) : quant_q;

  assign sts.tick_go    = (op_q == OP_TICK) && (lock_rd == '0);
  assign sts.idx_last   = idx == SLOT_W'(MAX_TASKS - 1);
  assign sts.pick_found = found || cand;
  assign sts.out_free   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= s_axis_tdata[OP_W-1:0];
      prio_q  <= s_axis_tdata[OP_W +: PRIO_W];
      quant_q <= s_axis_tdata[OP_W+PRIO_W +: QUANT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_prio[i]  <= '0;
        slot_quant[i] <= QUANT_W'(1);
        slot_ticks[i] <= TICK_W'(1);
        slot_lock[i]  <= '0;
      end
      running <= '0;
      used    <= CNT_W'(1);
    end else begin
      if (cmd.exec) begin
        case (op_q)
          OP_TICK: begin
            if (lock_rd == '0) begin
              slot_lock[rd_addr] <= LOCK_W'(1);
              if (ticks_rd != '0) slot_ticks[rd_addr] <= ticks_rd - TICK_W'(1);
            end
          end
          OP_CREATE: begin
            if (!table_full) begin
              slot_prio[new_slot]  <= prio_q;
              slot_quant[new_slot] <= quant_eff;
              slot_ticks[new_slot] <= quant_eff;
              slot_lock[new_slot]  <= LOCK_W'(1);
              used                 <= used + CNT_W'(1);
            end
          end
          OP_YIELD: begin
            slot_ticks[rd_addr] <= '0;
          end
          OP_LOCK: begin
            if (lock_rd != LOCK_MAX) slot_lock[rd_addr] <= lock_rd + LOCK_W'(1);
          end
          OP_UNLOCK: begin
            if (lock_rd != '0) slot_lock[rd_addr] <= lock_rd - LOCK_W'(1);
          end
          default: begin
          end
        endcase
      end
      if (cmd.refill && slot_ok) slot_ticks[rd_addr] <= quant_rd;
      if (cmd.handoff) begin
        running <= best;
        if (lock_rd != '0) slot_lock[rd_addr] <= lock_rd - LOCK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.scan || cmd.refill) begin
        idx <= idx + SLOT_W'(1);
        if (cand) found <= 1'b1;
      end
      if (cmd.idx_clr) begin
        idx   <= '0;
        found <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.scan || cmd.refill) && cand) begin
      best      <= idx;
      best_prio <= prio_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_created <= '0;
      res_status  <= ST_DONE;
      case (op_q)
        OP_TICK: begin
          if (lock_rd != '0) res_status <= ST_LOCKED;
        end
        OP_CREATE: begin
          if (table_full) begin
            res_status <= ST_FULL;
          end else begin
            res_created <= TASK_W'(new_slot);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cur     <= TASK_W'(running);
      out_created <= res_created;
      out_status  <= res_status;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - 2 * TASK_W - STAT_W){1'b0}},
                         out_status, out_created, out_cur};

endmodule

// File: hw/rtl/priority_quantum_task_scheduler.sv
// Priority quantum task scheduler, top level: joins controller and datapath.
// Depends on pqts_pkg, pqts_ctrl and pqts_datapath.
//
// Usage: each transfer on the s_axis channel carries one op (tick, create,
// yield, lock, unlock) with the priority and quantum of a task to create.
// Each op gives exactly one transfer on the m_axis channel: the slot now
// running, the slot given by a create, and a status code.
// An unlocked tick runs the slot scan, which reads one table entry a cycle
// (16 slots), and, if no slot has ticks left, then the refill pass, one
// slot a cycle, that also picks; every other op goes straight to the result.
// A new op is taken only once the previous result is in the output register.
// Reset: only the idle slot 0 exists, slot 0 runs, all locks are clear.
// A stalled receiver holds the result in the output register; the next op
// still runs, then waits until the register is free.
`timescale 1ns / 1ps

module priority_quantum_task_scheduler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // op [2:0], new_priority [10:3], new_quantum [18:11], zero fill above
  input  logic [pqts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // current_task [3:0], created_task [7:4], status [9:8], zero fill above
  output logic [pqts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import pqts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pqts_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  pqts_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_refill_finds: assert property (@(posedge clk) disable iff (rst)
    (cmd.refill && sts.idx_last) |-> sts.pick_found)
    else $error("refill pass ended without a pick");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("result shown without a load");

  a_refused_no_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2*TASK_W +: STAT_W] != ST_DONE)
      |-> m_axis_tdata[TASK_W +: TASK_W] == '0)
    else $error("slot reported for an op that did not complete");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && cmd.exec)
    else $error("op accepted while another is in flight");

endmodule
